### rtl/bsp_pkg.sv
// shared constants, command/status structs for the b-spline basis evaluator
// used by bsp_ctrl, bsp_datapath and bspline_basis_eval
package bsp_pkg;

  localparam int KNOTS      = 8;
  localparam int DEGREE     = 3;
  localparam int NB         = KNOTS - 1;      // degree-0 basis count
  localparam int KW         = 32;             // knot / xi width
  localparam int VW         = 48;             // result width
  localparam int IW         = 3;              // knot and basis index width
  localparam int DSW        = KW + 1;         // signed difference width
  localparam int DVW        = DSW + 16;       // dividend / quotient width
  localparam int DIV_STEPS  = DVW;
  localparam int CHW        = 16;             // multiplier chunk width
  localparam int MUL_CHUNKS = VW / CHW;
  localparam int PW         = 2 * VW;         // full product width
  localparam int CW         = 6;              // sequencer counter width

  localparam logic [VW-1:0] ONE_Q16 = VW'(65536);

  typedef struct packed {
    logic          accept;
    logic          init;
    logic [IW-1:0] idx;
    logic          ka_ld;
    logic          div_start;
    logic          div_step;
    logic          tsel;
    logic          mul_step;
    logic [1:0]    mul_k;
    logic          term_wr;
    logic          term_zero;
    logic          comb;
    logic          deriv;
    logic          rot;
    logic          emit;
    logic [IW-1:0] emit_idx;
    logic          emit_last;
  } bsp_cmd_t;

  typedef struct packed {
    logic bz0;
    logic bz1;
    logic out_free;
  } bsp_stat_t;

endpackage

### rtl/bspline_basis_eval.sv
// accept and set degree-0 bases; a recurrence term is zero if its basis input is zero,
// else bit-serial divided, chunk-multiplied and saturated; each basis is then combined
// and each level rotated back, then 1 beat per result unless the output is stalled
// one item at a time: next item accepted once the last beat is loaded
// rst is synchronous: knots return to 0,0,0,0,1.0,1.0,1.0,1.0 and the output empties
module bspline_basis_eval import bsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IW-1:0]        cfg_index,
  input  logic [KW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [KW-1:0]        xi,
  input  logic [2:0]           eval_degree,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IW-1:0]        basis_index,
  output logic signed [VW-1:0] value,
  output logic                 last
);

  bsp_cmd_t  cmd;
  bsp_stat_t stat;

  bsp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .eval_degree (eval_degree),
    .stat        (stat),
    .cmd         (cmd)
  );

  bsp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .xi          (xi),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .basis_index (basis_index),
    .value       (value),
    .last        (last)
  );

endmodule

### rtl/bsp_datapath.sv
// datapath: knot registers, basis shift line, shared divider and multiplier,
// output register; depends on bsp_pkg
module bsp_datapath import bsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  bsp_cmd_t             cmd,
  output bsp_stat_t            stat,
  input  logic                 cfg_we,
  input  logic [IW-1:0]        cfg_index,
  input  logic [KW-1:0]        cfg_data,
  input  logic [KW-1:0]        xi,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IW-1:0]        basis_index,
  output logic signed [VW-1:0] value,
  output logic                 last
);

  logic [KW-1:0]        knot [KNOTS];
  logic [KW-1:0]        x;
  logic [KW-1:0]        ka;
  logic signed [VW-1:0] q [NB];
  logic signed [VW-1:0] t1, t2;
  logic [DVW-1:0]       dvd;
  logic [DSW-1:0]       rem;
  logic [DSW-1:0]       dsr;
  logic                 qneg;
  logic [PW-1:0]        acc;

  logic [KW-1:0]        kb;
  logic signed [DSW-1:0] span, num;
  logic [DSW-1:0]       nmag, smag;
  logic [DSW:0]         remsh, rdiff;
  logic [DVW-1:0]       lim_r, rmag49;
  logic [VW-1:0]        rmag;
  logic signed [VW-1:0] bsel;
  logic                 bneg, tneg;
  logic [VW-1:0]        bmag;
  logic [CHW-1:0]       chunk;
  logic [VW+CHW-1:0]    pp;
  logic [PW-1:0]        pp_sh;
  logic [PW-17:0]       pmag;
  logic [PW-17:0]       lim_t;
  logic [VW-1:0]        tmag;
  logic signed [VW-1:0] term;
  logic signed [VW:0]   csum;
  logic signed [VW-1:0] csat;

  assign kb = knot[cmd.idx];

  always_comb begin
    span = $signed({1'b0, ka}) - $signed({1'b0, kb});
    if (span == '0) span = DSW'(65536);
    if (cmd.deriv) num = DSW'(DEGREE * 65536);
    else if (!cmd.tsel) num = $signed({1'b0, x}) - $signed({1'b0, kb});
    else num = $signed({1'b0, ka}) - $signed({1'b0, x});
    nmag = num[DSW-1] ? DSW'(-num) : DSW'(num);
    smag = span[DSW-1] ? DSW'(-span) : DSW'(span);
  end

  // restoring division, one quotient bit per cycle
  assign remsh = {rem, dvd[DVW-1]};
  assign rdiff = remsh - {1'b0, dsr};

  always_comb begin
    lim_r  = qneg ? (DVW'(1) << (VW - 1)) : ((DVW'(1) << (VW - 1)) - DVW'(1));
    rmag49 = (dvd > lim_r) ? lim_r : dvd;
    rmag   = rmag49[VW-1:0];
    bsel   = cmd.tsel ? q[1] : q[0];
    bneg   = bsel[VW-1];
    bmag   = bneg ? VW'(-bsel) : VW'(bsel);
    chunk  = bmag[cmd.mul_k*CHW +: CHW];
    pp     = rmag * chunk;
    pp_sh  = {{(PW-VW-CHW){1'b0}}, pp} << (CHW * cmd.mul_k);
    tneg   = qneg ^ bneg;
    pmag   = acc[PW-1:16];
    lim_t  = tneg ? ((PW-16)'(1) << (VW - 1)) : (((PW-16)'(1) << (VW - 1)) - (PW-16)'(1));
    tmag   = (pmag > lim_t) ? lim_t[VW-1:0] : pmag[VW-1:0];
    term   = tneg ? -$signed(tmag) : $signed(tmag);
    if (cmd.term_zero) term = '0;
    csum   = cmd.deriv ? ({t1[VW-1], t1} - {t2[VW-1], t2})
                       : ({t1[VW-1], t1} + {t2[VW-1], t2});
    if (csum[VW] != csum[VW-1])
      csat = csum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    else
      csat = csum[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KNOTS; k++) knot[k] <= (k < 4) ? KW'(0) : KW'(65536);
    end else if (cfg_we && int'(cfg_index) < KNOTS) begin
      knot[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) x <= xi;
    if (cmd.ka_ld) ka <= kb;
    if (cmd.div_start) begin
      dvd  <= {nmag, 16'b0};
      rem  <= '0;
      dsr  <= smag;
      qneg <= num[DSW-1] ^ span[DSW-1];
    end else if (cmd.div_step) begin
      if (!rdiff[DSW]) begin
        rem <= rdiff[DSW-1:0];
        dvd <= {dvd[DVW-2:0], 1'b1};
      end else begin
        rem <= remsh[DSW-1:0];
        dvd <= {dvd[DVW-2:0], 1'b0};
      end
    end
    if (cmd.mul_step) acc <= ((cmd.mul_k == 2'd0) ? '0 : acc) + pp_sh;
    if (cmd.term_wr) begin
      if (cmd.tsel) t2 <= term;
      else t1 <= term;
    end
    if (cmd.init) begin
      for (int j = 0; j < NB; j++)
        q[j] <= (knot[j] <= x && x < knot[j+1]) ? ONE_Q16 : '0;
    end else if (cmd.comb) begin
      for (int j = 0; j < NB - 1; j++) q[j] <= q[j+1];
      q[NB-1] <= csat;
    end else if (cmd.rot || cmd.emit) begin
      for (int j = 0; j < NB - 1; j++) q[j] <= q[j+1];
      q[NB-1] <= q[0];
    end
    if (cmd.emit) begin
      basis_index <= cmd.emit_idx;
      value       <= q[0];
      last        <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.bz0      = (q[0] == '0);
  assign stat.bz1      = (q[1] == '0);
  assign stat.out_free = !out_valid || !out_stall;

endmodule

### rtl/bsp_ctrl.sv
// sequencer: walks recurrence levels, terms, divider and multiplier steps,
// then streams results; depends on bsp_pkg
module bsp_ctrl import bsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [2:0] eval_degree,
  input  bsp_stat_t  stat,
  output bsp_cmd_t   cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_INIT = 11'b00000000010,
    S_TERM = 11'b00000000100,
    S_KA   = 11'b00000001000,
    S_KB   = 11'b00000010000,
    S_DIV  = 11'b00000100000,
    S_MUL  = 11'b00001000000,
    S_SAT  = 11'b00010000000,
    S_COMB = 11'b00100000000,
    S_ROT  = 11'b01000000000,
    S_EMIT = 11'b10000000000
  } state_t;

  localparam logic [IW-1:0] DEG  = IW'(DEGREE);
  localparam logic [IW-1:0] NBI  = IW'(NB);

  state_t        state, state_next;
  logic          op_r;
  logic [IW-1:0] nlev, lvl, j, ecnt;
  logic          tsel;
  logic [CW-1:0] cnt;
  logic [IW-1:0] nout, count;
  logic          acc_in, bz, elast;

  assign in_stall = (state != S_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign nout     = NBI - lvl;
  assign count    = NBI - nlev;
  assign bz       = tsel ? stat.bz1 : stat.bz0;
  assign elast    = (ecnt == count - IW'(1));

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.tsel       = tsel;
    cmd.deriv      = op_r && (lvl == DEG);
    cmd.mul_k      = cnt[1:0];
    cmd.emit_idx   = ecnt;
    cmd.emit_last  = elast;
    case (state)
      S_IDLE: begin
        cmd.accept = acc_in;
        if (acc_in) state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = (nlev == '0) ? S_EMIT : S_TERM;
      end
      S_TERM: begin
        if (bz) begin
          // product with a zero basis is zero, skip the divide
          cmd.term_wr   = 1'b1;
          cmd.term_zero = 1'b1;
          state_next    = tsel ? S_COMB : S_TERM;
        end else begin
          state_next = S_KA;
        end
      end
      S_KA: begin
        cmd.idx    = j + lvl + IW'(tsel);
        cmd.ka_ld  = 1'b1;
        state_next = S_KB;
      end
      S_KB: begin
        cmd.idx       = j + IW'(tsel);
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt == CW'(MUL_CHUNKS - 1)) state_next = S_SAT;
      end
      S_SAT: begin
        cmd.term_wr = 1'b1;
        state_next  = tsel ? S_COMB : S_TERM;
      end
      S_COMB: begin
        cmd.comb   = 1'b1;
        state_next = (j == nout - IW'(1)) ? S_ROT : S_TERM;
      end
      S_ROT: begin
        // bring the new level back to the head of the shift line
        cmd.rot = 1'b1;
        if (cnt == CW'(lvl - IW'(1))) state_next = (lvl == nlev) ? S_EMIT : S_TERM;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (elast) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_r  <= 1'b0;
      nlev  <= '0;
      lvl   <= '0;
      j     <= '0;
      ecnt  <= '0;
      tsel  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            op_r <= op;
            nlev <= op ? DEG : ((eval_degree > DEG) ? DEG : eval_degree);
            lvl  <= IW'(1);
            j    <= '0;
            tsel <= 1'b0;
            ecnt <= '0;
            cnt  <= '0;
          end
        end
        S_TERM: begin
          if (bz && !tsel) tsel <= 1'b1;
        end
        S_KB:   cnt <= '0;
        S_DIV:  cnt <= (cnt == CW'(DIV_STEPS - 1)) ? '0 : cnt + CW'(1);
        S_MUL:  cnt <= cnt + CW'(1);
        S_SAT: begin
          cnt <= '0;
          if (!tsel) tsel <= 1'b1;
        end
        S_COMB: begin
          tsel <= 1'b0;
          cnt  <= '0;
          if (j == nout - IW'(1)) j <= '0;
          else j <= j + IW'(1);
        end
        S_ROT: begin
          if (cnt == CW'(lvl - IW'(1))) begin
            cnt <= '0;
            lvl <= lvl + IW'(1);
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_EMIT: begin
          if (stat.out_free) ecnt <= ecnt + IW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
